/* src/assert_macros.svh */
// Assertion helpers: concurrent checks, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

/* src/psfwc_pkg.sv */
package psfwc_pkg;

  localparam int MAX_SLICES      = 256;
  localparam int SLICE_AW        = $clog2(MAX_SLICES);
  localparam int CNT_W           = SLICE_AW + 1;
  localparam int MAX_HALF_WINDOW = 8;
  localparam int HW_W            = $clog2(MAX_HALF_WINDOW + 1);

  localparam int WIDTH_W  = 28;
  localparam int SLICE_W  = 8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  // exponent limit, Q8
  localparam logic [11:0] A_MAX = 12'd2303;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_PITCH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CENTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA       = 3'd5;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  typedef logic [16:0] q16_t;

  // exp(-i), Q16
  function automatic q16_t exp_int_q16(input logic [3:0] i);
    q16_t v;
    case (i)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-h/16), Q16
  function automatic q16_t exp_sixteenth_q16(input logic [3:0] h);
    q16_t v;
    case (h)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-l/256), Q16
  function automatic q16_t exp_fine_q16(input logic [3:0] l);
    q16_t v;
    case (l)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62781;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

/* src/psfwc_ram.sv */
module psfwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/psf_width_calibration_and_lookup_top.sv */
// PSF width calibration and lookup. Pixel items (tuser 0) of a calibration slice
// accumulate a background-subtracted weight and a weighted squared distance from
// the configured axis centre; the item flagged tlast closes the slice and returns
// width = floor(sqrt(256*S/W)) in nm Q4, which is also stored in a 256-entry width
// table. Query items (tuser 1) map a z position to the nearest slice and return
// the Gaussian-weighted mean of stored widths over +/- round(2*sigma) slices, at most 8.
// One item is handled at a time by a sequencer around a single 28x26 multiplier
// and one shared shift/subtract unit (restoring divide, bit-pair square root).
// A pixel passes through the multiply, square and accumulate states; the closing pixel
// then runs a 72-step divide and a 32-step root before storing, or skips both when its
// weight is zero. A query runs a divide to find its window, then for each slice in it
// a 23-step divide for its Gaussian exponent (skipped for the centre slice or zero
// sigma), then a final divide before output, skipped when the window is empty.
// A result that cannot leave holds the sequencer until the output register frees.
// The result sits in an output register, so the next item may enter while it waits.
// Configuration writes are taken at any time; write only when the block is idle.
`include "assert_macros.svh"

module psf_width_calibration_and_lookup_top (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: pixel_value[15:0], axis_coord[25:16], query_z_nm[49:26], zero pad
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [psfwc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                               s_tuser,  // opcode
  input  logic                               s_tlast,  // last_of_slice
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: width_nm_q4[27:0], slice_number[35:28], zero pad
  output logic [psfwc_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tuser: result_kind[0], below_threshold[1], empty_window[2]
  output logic [psfwc_pkg::M_TUSER_W-1:0]    m_tuser,
  input  logic                               cfg_we,
  input  logic [psfwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psfwc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_P_MUL   = 5'd1;
  localparam logic [4:0] ST_P_ABS   = 5'd2;
  localparam logic [4:0] ST_P_SQ    = 5'd3;
  localparam logic [4:0] ST_P_LO    = 5'd4;
  localparam logic [4:0] ST_P_HI    = 5'd5;
  localparam logic [4:0] ST_P_TERM  = 5'd6;
  localparam logic [4:0] ST_P_ADD   = 5'd7;
  localparam logic [4:0] ST_F_DIV   = 5'd8;
  localparam logic [4:0] ST_F_ROOT  = 5'd9;
  localparam logic [4:0] ST_F_WIDTH = 5'd10;
  localparam logic [4:0] ST_F_STORE = 5'd11;
  localparam logic [4:0] ST_Q_CTR   = 5'd12;
  localparam logic [4:0] ST_Q_WIN   = 5'd13;
  localparam logic [4:0] ST_Q_BND   = 5'd14;
  localparam logic [4:0] ST_Q_A     = 5'd15;
  localparam logic [4:0] ST_Q_AD    = 5'd16;
  localparam logic [4:0] ST_Q_AR    = 5'd17;
  localparam logic [4:0] ST_Q_W1    = 5'd18;
  localparam logic [4:0] ST_Q_W2    = 5'd19;
  localparam logic [4:0] ST_Q_W3    = 5'd20;
  localparam logic [4:0] ST_Q_W4    = 5'd21;
  localparam logic [4:0] ST_Q_MW    = 5'd22;
  localparam logic [4:0] ST_Q_AC    = 5'd23;
  localparam logic [4:0] ST_Q_FIN   = 5'd24;
  localparam logic [4:0] ST_Q_RES   = 5'd25;
  localparam logic [4:0] ST_RUN     = 5'd26;
  localparam logic [4:0] ST_EMIT    = 5'd27;

  localparam logic [psfwc_pkg::CNT_W-1:0] CNT_MAX = psfwc_pkg::CNT_W'(psfwc_pkg::MAX_SLICES);

  // configuration
  logic [15:0] axis_pitch;
  logic [23:0] axis_center;
  logic [15:0] threshold;
  logic [15:0] z_pitch;
  logic [23:0] z_center;
  logic [6:0]  sigma;

  logic [4:0]  state;

  // latched item
  logic        last;
  logic [9:0]  coord;
  logic [23:0] qz;
  logic [15:0] wv;

  // accumulators
  logic [63:0]                     sq_sum;
  logic [39:0]                     w_sum;
  logic [psfwc_pkg::CNT_W-1:0]     slice_counter;

  // pixel datapath
  logic [25:0] ad;
  logic [51:0] d2;
  logic [41:0] lo;
  logic [63:0] term;

  // shared multiplier
  logic [27:0] mul_a;
  logic [25:0] mul_b;
  logic [53:0] prod;

  // shared shift/subtract unit
  logic [71:0] shreg;
  logic [41:0] rem;
  logic [39:0] su_div;
  logic [31:0] root;
  logic [6:0]  su_cnt;
  logic        su_sqrt;
  logic [4:0]  su_ret;
  logic [41:0] pr;
  logic [41:0] trial;
  logic [42:0] sub;
  logic        ge;

  // query datapath
  logic                            q_neg;
  logic [27:0]                     c;
  logic [psfwc_pkg::HW_W-1:0]      bw;
  logic [psfwc_pkg::SLICE_AW-1:0]  k;
  logic [psfwc_pkg::SLICE_AW-1:0]  khi;
  logic [3:0]                      kdist;
  logic [11:0]                     a_exp;
  logic [16:0]                     w1;
  logic [16:0]                     wq;
  logic [20:0]                     wsum;
  logic [49:0]                     acc;

  // result
  logic                              res_kind;
  logic                              res_below;
  logic                              res_empty;
  logic [psfwc_pkg::WIDTH_W-1:0]     res_width;
  logic [psfwc_pkg::SLICE_W-1:0]     res_slice;

  // combinational helpers
  logic [15:0] in_pix;
  logic [26:0] dsig;
  logic [64:0] term_sum;
  logic [64:0] s_add;
  logic [40:0] w_add;
  logic [25:0] zc;
  logic [25:0] zc_abs;
  logic [15:0] zp;
  logic [26:0] c_dvd;
  logic [7:0]  bsum;
  logic [4:0]  bq;
  logic [27:0] lo_s;
  logic [27:0] hi_s;
  logic [27:0] nm1;
  logic [27:0] lo_c;
  logic [27:0] hi_c;
  logic [27:0] shown;
  logic [27:0] kd;
  logic [27:0] kabs;
  logic [13:0] s2;
  logic [22:0] a_dvd;
  logic [49:0] fin_dvd;
  logic [63:0] rad;

  logic [psfwc_pkg::WIDTH_W-1:0] rd_data;
  logic                          wr_en;
  logic                          rd_en;
  logic                          emit_fire;

  assign s_tready  = (state == ST_IDLE);
  assign in_pix    = s_tdata[15:0];
  // result leaves the sequencer when the output register is free or draining
  assign emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_P_MUL: begin
        mul_a = 28'(coord);
        mul_b = 26'(axis_pitch);
      end
      ST_P_SQ: begin
        mul_a = 28'(ad);
        mul_b = ad;
      end
      ST_P_LO: begin
        mul_a = 28'(prod[25:0]);
        mul_b = 26'(wv);
      end
      ST_P_HI: begin
        mul_a = 28'(d2[51:26]);
        mul_b = 26'(wv);
      end
      ST_Q_W1: begin
        mul_a = 28'(psfwc_pkg::exp_int_q16(a_exp[11:8]));
        mul_b = 26'(psfwc_pkg::exp_sixteenth_q16(a_exp[7:4]));
      end
      ST_Q_W3: begin
        mul_a = 28'(w1);
        mul_b = 26'(psfwc_pkg::exp_fine_q16(a_exp[3:0]));
      end
      ST_Q_MW: begin
        mul_a = rd_data;
        mul_b = 26'(wq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shift/subtract step: divide takes one quotient bit, root one bit pair
  always_comb begin
    if (su_sqrt) begin
      pr    = {rem[39:0], shreg[71:70]};
      trial = {8'd0, root, 2'b01};
    end else begin
      pr    = {rem[40:0], shreg[71]};
      trial = {2'd0, su_div};
    end
    sub = {1'b0, pr} - {1'b0, trial};
    ge  = !sub[42];
  end

  // pixel arithmetic
  always_comb begin
    dsig     = {1'b0, prod[25:0]} - {3'd0, axis_center};
    term_sum = {1'b0, prod[37:0], 26'd0} + {23'd0, lo};
    s_add    = {1'b0, sq_sum} + {1'b0, term};
    w_add    = {1'b0, w_sum} + 41'(wv);
    rad      = (|shreg[71:64]) ? '1 : shreg[63:0];
  end

  // query arithmetic
  always_comb begin
    zc      = {2'd0, z_center} - {{2{qz[23]}}, qz};
    zc_abs  = zc[25] ? (26'd0 - zc) : zc;
    zp      = (z_pitch == 16'd0) ? 16'd1 : z_pitch;
    c_dvd   = 27'({zc_abs[24:0], 1'b0}) + 27'(zp);
    bsum    = 8'(sigma) + 8'd4;
    bq      = bsum[7:3];
    lo_s    = c - 28'(bw);
    hi_s    = c + 28'(bw);
    nm1     = 28'(slice_counter) - 28'd1;
    lo_c    = lo_s[27] ? 28'd0 : lo_s;
    hi_c    = ($signed(hi_s) > $signed(nm1)) ? nm1 : hi_s;
    shown   = ($signed(c) > $signed(nm1)) ? nm1 : c;
    if (shown[27]) begin
      shown = 28'd0;
    end
    kd      = 28'(k) - c;
    kabs    = kd[27] ? (28'd0 - kd) : kd;
    s2      = 14'(sigma) * 14'(sigma);
    a_dvd   = {7'(kdist) * 7'(kdist), 16'd0} + 23'(s2);
    fin_dvd = acc + 50'(wsum[20:1]);
  end

  assign wr_en = (state == ST_F_STORE) && !slice_counter[psfwc_pkg::SLICE_AW];
  assign rd_en = (state == ST_Q_A);

  psfwc_ram #(
    .WIDTH (psfwc_pkg::WIDTH_W),
    .DEPTH (psfwc_pkg::MAX_SLICES)
  ) u_width_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slice_counter[psfwc_pkg::SLICE_AW-1:0]),
    .wr_data (res_width),
    .rd_en   (rd_en),
    .rd_addr (k),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    prod <= 54'(mul_a) * 54'(mul_b);
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      sq_sum        <= '0;
      w_sum         <= '0;
      slice_counter <= '0;
      axis_pitch    <= 16'd100;
      axis_center   <= '0;
      threshold     <= '0;
      z_pitch       <= 16'd100;
      z_center      <= '0;
      sigma         <= 7'd5;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          psfwc_pkg::REG_AXIS_PITCH:  axis_pitch  <= cfg_data[15:0];
          psfwc_pkg::REG_AXIS_CENTER: axis_center <= cfg_data;
          psfwc_pkg::REG_THRESHOLD:   threshold   <= cfg_data[15:0];
          psfwc_pkg::REG_Z_PITCH:     z_pitch     <= cfg_data[15:0];
          psfwc_pkg::REG_Z_CENTER:    z_center    <= cfg_data;
          psfwc_pkg::REG_SIGMA:       sigma       <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            last  <= s_tlast;
            coord <= s_tdata[25:16];
            qz    <= s_tdata[49:26];
            wv    <= (in_pix > threshold) ? (in_pix - threshold) : 16'd0;
            state <= s_tuser ? ST_Q_CTR : ST_P_MUL;
          end
        end
        ST_P_MUL:  state <= ST_P_ABS;
        ST_P_ABS: begin
          ad    <= dsig[26] ? 26'(27'd0 - dsig) : dsig[25:0];
          state <= ST_P_SQ;
        end
        ST_P_SQ:   state <= ST_P_LO;
        ST_P_LO: begin
          d2    <= prod[51:0];
          state <= ST_P_HI;
        end
        ST_P_HI: begin
          lo    <= prod[41:0];
          state <= ST_P_TERM;
        end
        ST_P_TERM: begin
          // prod holds the high partial product
          term  <= ((|prod[41:38]) || term_sum[64]) ? '1 : term_sum[63:0];
          state <= ST_P_ADD;
        end
        ST_P_ADD: begin
          sq_sum <= s_add[64] ? '1 : s_add[63:0];
          w_sum  <= w_add[40] ? '1 : w_add[39:0];
          state  <= last ? ST_F_DIV : ST_IDLE;
        end
        ST_F_DIV: begin
          res_kind  <= 1'b0;
          res_empty <= 1'b0;
          if (w_sum == '0) begin
            res_below <= 1'b1;
            res_width <= '0;
            state     <= ST_F_STORE;
          end else begin
            res_below <= 1'b0;
            shreg     <= {sq_sum, 8'd0};
            su_div    <= w_sum;
            rem       <= '0;
            su_sqrt   <= 1'b0;
            su_cnt    <= 7'd72;
            su_ret    <= ST_F_ROOT;
            state     <= ST_RUN;
          end
        end
        ST_F_ROOT: begin
          shreg   <= {rad, 8'd0};
          rem     <= '0;
          root    <= '0;
          su_sqrt <= 1'b1;
          su_cnt  <= 7'd32;
          su_ret  <= ST_F_WIDTH;
          state   <= ST_RUN;
        end
        ST_F_WIDTH: begin
          res_width <= (|root[31:28]) ? psfwc_pkg::WIDTH_MAX : root[27:0];
          state     <= ST_F_STORE;
        end
        ST_F_STORE: begin
          res_slice <= slice_counter[psfwc_pkg::SLICE_W-1:0];
          if (!slice_counter[psfwc_pkg::SLICE_AW]) begin
            slice_counter <= slice_counter + 1'b1;
          end
          sq_sum <= '0;
          w_sum  <= '0;
          state  <= ST_EMIT;
        end
        ST_Q_CTR: begin
          res_kind  <= 1'b1;
          res_below <= 1'b0;
          q_neg     <= zc[25];
          shreg     <= {c_dvd, 45'd0};
          su_div    <= 40'({zp, 1'b0});
          rem       <= '0;
          su_sqrt   <= 1'b0;
          su_cnt    <= 7'd27;
          su_ret    <= ST_Q_WIN;
          state     <= ST_RUN;
        end
        ST_Q_WIN: begin
          c     <= q_neg ? (28'd0 - 28'(shreg[26:0])) : 28'(shreg[26:0]);
          bw    <= (bq > 5'(psfwc_pkg::MAX_HALF_WINDOW))
                   ? psfwc_pkg::HW_W'(psfwc_pkg::MAX_HALF_WINDOW)
                   : bq[psfwc_pkg::HW_W-1:0];
          state <= ST_Q_BND;
        end
        ST_Q_BND: begin
          res_slice <= shown[psfwc_pkg::SLICE_W-1:0];
          acc       <= '0;
          wsum      <= '0;
          k         <= lo_c[psfwc_pkg::SLICE_AW-1:0];
          khi       <= hi_c[psfwc_pkg::SLICE_AW-1:0];
          state     <= ($signed(lo_c) > $signed(hi_c)) ? ST_Q_FIN : ST_Q_A;
        end
        ST_Q_A: begin
          // window bounds keep the distance within the half window
          kdist <= kabs[3:0];
          state <= ST_Q_AD;
        end
        ST_Q_AD: begin
          if (kdist == 4'd0 || sigma == 7'd0) begin
            a_exp <= '0;
            state <= ST_Q_W1;
          end else begin
            shreg   <= {a_dvd, 49'd0};
            su_div  <= 40'({s2, 1'b0});
            rem     <= '0;
            su_sqrt <= 1'b0;
            su_cnt  <= 7'd23;
            su_ret  <= ST_Q_AR;
            state   <= ST_RUN;
          end
        end
        ST_Q_AR: begin
          a_exp <= (shreg[22:0] > 23'(psfwc_pkg::A_MAX)) ? psfwc_pkg::A_MAX : shreg[11:0];
          state <= ST_Q_W1;
        end
        ST_Q_W1:   state <= ST_Q_W2;
        ST_Q_W2: begin
          w1    <= 17'((prod[33:0] + 34'd32768) >> 16);
          state <= ST_Q_W3;
        end
        ST_Q_W3:   state <= ST_Q_W4;
        ST_Q_W4: begin
          wq    <= 17'((prod[33:0] + 34'd32768) >> 16);
          state <= ST_Q_MW;
        end
        ST_Q_MW: begin
          wsum  <= wsum + 21'(wq);
          state <= ST_Q_AC;
        end
        ST_Q_AC: begin
          acc <= acc + 50'(prod[44:0]);
          if (k == khi) begin
            state <= ST_Q_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= ST_Q_A;
          end
        end
        ST_Q_FIN: begin
          if (wsum == '0) begin
            res_empty <= 1'b1;
            res_width <= '0;
            state     <= ST_EMIT;
          end else begin
            shreg   <= {fin_dvd, 22'd0};
            su_div  <= 40'(wsum);
            rem     <= '0;
            su_sqrt <= 1'b0;
            su_cnt  <= 7'd50;
            su_ret  <= ST_Q_RES;
            state   <= ST_RUN;
          end
        end
        ST_Q_RES: begin
          res_empty <= 1'b0;
          res_width <= (|shreg[49:28]) ? psfwc_pkg::WIDTH_MAX : shreg[27:0];
          state     <= ST_EMIT;
        end
        ST_RUN: begin
          rem <= ge ? sub[41:0] : pr;
          if (su_sqrt) begin
            shreg <= {shreg[69:0], 2'b00};
            root  <= {root[30:0], ge};
          end else begin
            shreg <= {shreg[70:0], ge};
          end
          su_cnt <= su_cnt - 1'b1;
          if (su_cnt == 7'd1) begin
            state <= su_ret;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            m_tdata  <= {4'd0, res_slice, res_width};
            m_tuser  <= {res_empty, res_below, res_kind};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_cnt_bound, clk, rst, 1'b1, slice_counter <= CNT_MAX)
  `ASSERT_IMPLY(a_run_cnt, clk, rst, state == ST_RUN, su_cnt != 7'd0)
  `ASSERT_IMPLY(a_query_flags, clk, rst, m_tvalid && m_tuser[0], !m_tuser[1])
  `ASSERT_IMPLY(a_empty_zero, clk, rst, m_tvalid && m_tuser[2], m_tdata[27:0] == 28'd0)
  `ASSERT_NEXT(a_store_count, clk, rst, wr_en, slice_counter == $past(slice_counter) + 1'b1)

endmodule

/* verif/tb_psf_width_calibration_and_lookup_top.sv */
`timescale 1ns / 100ps

module tb_psf_width_calibration_and_lookup_top;

  // Predicts slice widths and smoothed width lookups, holds the results due
  class width_scoreboard;
    typedef struct {
      bit        kind;
      bit [27:0] width;
      bit [7:0]  slice;
      bit        below;
      bit        empty;
    } width_result_t;

    int unsigned e_int[9] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22};
    int unsigned e_sixteenth[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
      45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    int unsigned e_fine[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
      63768, 63520, 63272, 63025, 62781, 62535, 62291, 62048, 61806};

    bit [15:0] axis_pitch;
    bit [23:0] axis_centre;
    bit [15:0] threshold;
    bit [15:0] z_pitch;
    bit [23:0] z_centre;
    bit [6:0]  sigma;

    longint unsigned sq_sum;
    longint unsigned wt_sum;
    int unsigned     nslices;
    bit [27:0]       widths[psfwc_pkg::MAX_SLICES];
    width_result_t   due[$];
    int              errors;

    function new();
      axis_pitch = 100;
      axis_centre = 0;
      threshold = 0;
      z_pitch = 100;
      z_centre = 0;
      sigma = 5;
      sq_sum = 0;
      wt_sum = 0;
      nslices = 0;
      errors = 0;
    endfunction

    function void set_reg(bit [psfwc_pkg::CFG_IDX_W-1:0] idx,
                          bit [psfwc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        psfwc_pkg::REG_AXIS_PITCH:  axis_pitch = val[15:0];
        psfwc_pkg::REG_AXIS_CENTER: axis_centre = val;
        psfwc_pkg::REG_THRESHOLD:   threshold = val[15:0];
        psfwc_pkg::REG_Z_PITCH:     z_pitch = val[15:0];
        psfwc_pkg::REG_Z_CENTER:    z_centre = val;
        psfwc_pkg::REG_SIGMA:       sigma = val[6:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned gauss_q16(longint unsigned kdist, longint unsigned s);
      longint unsigned a, s2, w;
      a = 0;
      if (kdist != 0 && s != 0) begin
        s2 = s * s;
        a = (65536 * kdist * kdist + s2) / (2 * s2);
      end
      if (a > 2303) a = 2303;
      w = (longint'(e_int[a >> 8]) * e_sixteenth[(a >> 4) & 15] + 32768) >> 16;
      w = (w * e_fine[a & 15] + 32768) >> 16;
      return w;
    endfunction

    function void close_slice();
      width_result_t   r;
      longint unsigned q, rem, x, root;
      r.kind = 0;
      r.width = 0;
      r.below = (wt_sum == 0);
      r.empty = 0;
      r.slice = nslices[7:0];
      if (!r.below) begin
        q = sq_sum / wt_sum;
        rem = sq_sum % wt_sum;
        if (q > (64'hFFFF_FFFF_FFFF_FFFF >> 8)) x = 64'hFFFF_FFFF_FFFF_FFFF;
        else x = (q << 8) + (rem << 8) / wt_sum;
        root = int_sqrt(x);
        r.width = (root > 64'h0FFF_FFFF) ? 28'hFFF_FFFF : root[27:0];
      end
      due = {due, r};
      if (nslices < psfwc_pkg::MAX_SLICES) begin
        widths[nslices] = r.width;
        nslices++;
      end
      sq_sum = 0;
      wt_sum = 0;
    endfunction

    function void lookup(bit [23:0] qz);
      width_result_t   r;
      longint          z, zc, c, lo, hi, k, n;
      longint unsigned m, p, b, acc, wsum, w, v;
      z = longint'($signed(qz));
      zc = longint'(z_centre) - z;
      m = (zc < 0) ? -zc : zc;
      p = (z_pitch == 0) ? 1 : z_pitch;
      c = (2 * m + p) / (2 * p);
      if (zc < 0) c = -c;
      b = (sigma + 4) / 8;
      if (b > psfwc_pkg::MAX_HALF_WINDOW) b = psfwc_pkg::MAX_HALF_WINDOW;
      n = nslices;
      lo = (c - longint'(b) < 0) ? 0 : c - longint'(b);
      hi = (c + longint'(b) > n - 1) ? n - 1 : c + longint'(b);
      acc = 0;
      wsum = 0;
      for (k = lo; k <= hi; k++) begin
        w = gauss_q16((k > c) ? k - c : c - k, sigma);
        acc += longint'(widths[k]) * w;
        wsum += w;
      end
      r.kind = 1;
      r.below = 0;
      if (c > n - 1) c = n - 1;
      if (c < 0) c = 0;
      r.slice = c[7:0];
      r.empty = (wsum == 0);
      r.width = 0;
      if (wsum != 0) begin
        v = (acc + wsum / 2) / wsum;
        r.width = (v > 64'h0FFF_FFFF) ? 28'hFFF_FFFF : v[27:0];
      end
      due = {due, r};
    endfunction

    function void note_input(bit op, bit [15:0] pix, bit [9:0] coord, bit last,
                             bit [23:0] qz);
      longint unsigned w, ad, d2, term;
      longint          d;
      bit [127:0]      prod;
      bit [64:0]       s65;
      if (op) begin
        lookup(qz);
      end else begin
        w = (pix > threshold) ? pix - threshold : 0;
        if (w != 0) begin
          d = longint'(coord) * longint'(axis_pitch) - longint'(axis_centre);
          ad = (d < 0) ? -d : d;
          d2 = ad * ad;
          prod = {64'd0, d2} * {64'd0, w};
          term = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
          s65 = {1'b0, sq_sum} + {1'b0, term};
          sq_sum = s65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s65[63:0];
          wt_sum = (w > 64'hFF_FFFF_FFFF - wt_sum) ? 64'hFF_FFFF_FFFF : wt_sum + w;
        end
        if (last) close_slice();
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit kind, bit [27:0] width, bit [7:0] slice,
                      bit below, bit empty);
      width_result_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected result kind %0d width %0d", kind, width));
        return;
      end
      e = due.pop_front();
      if (kind != e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
      if (width != e.width) report($sformatf("width %0d, want %0d", width, e.width));
      if (slice != e.slice) report($sformatf("slice %0d, want %0d", slice, e.slice));
      if (below != e.below) report($sformatf("below %0d, want %0d", below, e.below));
      if (empty != e.empty) report($sformatf("empty %0d, want %0d", empty, e.empty));
    endtask
  endclass

  logic                               clk = 0;
  logic                               rst = 1;
  logic                               s_tvalid = 0;
  logic                               s_tready;
  logic [psfwc_pkg::S_TDATA_W-1:0]    s_tdata = '0;
  logic                               s_tuser = 0;
  logic                               s_tlast = 0;
  logic                               m_tvalid;
  logic                               m_tready = 0;
  logic [psfwc_pkg::M_TDATA_W-1:0]    m_tdata;
  logic [psfwc_pkg::M_TUSER_W-1:0]    m_tuser;
  logic                               cfg_we = 0;
  logic [psfwc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [psfwc_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  width_scoreboard sb;
  int send_idle_pct = 0;   // chance of a gap before each item
  int recv_stall_pct = 0;  // chance of tready low in a cycle
  int hold_left = 0;       // long receiver hold-off, counted down below

  psf_width_calibration_and_lookup_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, plus the long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Accepted items feed the predictor; accepted results are checked
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_input(s_tuser, s_tdata[15:0], s_tdata[25:16], s_tlast, s_tdata[49:26]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser[0], m_tdata[27:0], m_tdata[35:28], m_tuser[1], m_tuser[2]);
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(bit op, bit [15:0] pix, bit [9:0] coord, bit last,
                           bit [23:0] qz);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {6'd0, qz, coord, pix};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic pixel(bit [15:0] pix, bit [9:0] coord, bit last);
    push_item(0, pix, coord, last, 24'($urandom()));
  endtask

  task automatic query(bit [23:0] qz);
    push_item(1, 16'($urandom()), 10'($urandom()), 1'($urandom()), qz);
  endtask

  // Sender stops until every result is in, then covers a pixel still in flight
  task automatic drain();
    s_tvalid <= 0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(bit [psfwc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= psfwc_pkg::CFG_DATA_W'(val);
    sb.set_reg(idx, psfwc_pkg::CFG_DATA_W'(val));
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Slice of 1..4 pixels, coordinates mostly around the configured centre
  task automatic rand_slice();
    int        len, mid;
    bit [15:0] pix;
    bit [9:0]  coord;
    len = $urandom_range(1, 4);
    mid = int'(sb.axis_centre / sb.axis_pitch);
    if (mid > 1023) mid = 1023;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) < 7) begin
        pix = 16'(sb.threshold + $urandom_range(0, 4000));
        coord = 10'(mid + $urandom_range(0, 10) - 5);
      end else begin
        pix = 16'($urandom());
        coord = 10'($urandom());
      end
      pixel(pix, coord, i == len - 1);
    end
  endtask

  // Query aimed near a stored slice, sometimes anywhere
  task automatic rand_query();
    longint t;
    int     c;
    if ($urandom_range(4) == 0) begin
      query(24'($urandom()));
    end else begin
      c = $urandom_range(0, sb.nslices + 6) - 3;
      t = longint'(sb.z_centre) - longint'(c) * sb.z_pitch
          + $urandom_range(0, sb.z_pitch) - sb.z_pitch / 2;
      if (t > 8388607) t = 8388607;
      if (t < -8388608) t = -8388608;
      query(t[23:0]);
    end
  endtask

  task automatic rand_config(int style);
    case (style)
      0: begin
        write_reg(psfwc_pkg::REG_AXIS_PITCH, $urandom_range(50, 200));
        write_reg(psfwc_pkg::REG_AXIS_CENTER, sb.axis_pitch * $urandom_range(0, 1023));
        write_reg(psfwc_pkg::REG_THRESHOLD, $urandom_range(0, 2000));
        write_reg(psfwc_pkg::REG_Z_PITCH, $urandom_range(10, 200));
        write_reg(psfwc_pkg::REG_Z_CENTER, $urandom_range(0, sb.z_pitch * 40));
        write_reg(psfwc_pkg::REG_SIGMA, $urandom_range(1, 65));
      end
      1: begin
        write_reg(psfwc_pkg::REG_AXIS_PITCH, $urandom_range(1, 65535));
        write_reg(psfwc_pkg::REG_AXIS_CENTER, $urandom());
        write_reg(psfwc_pkg::REG_THRESHOLD, $urandom_range(0, 65535));
        write_reg(psfwc_pkg::REG_Z_PITCH, $urandom_range(1, 65535));
        write_reg(psfwc_pkg::REG_Z_CENTER, $urandom());
        write_reg(psfwc_pkg::REG_SIGMA, $urandom_range(1, 127));
      end
      2: begin
        write_reg(psfwc_pkg::REG_AXIS_PITCH, 65535);
        write_reg(psfwc_pkg::REG_AXIS_CENTER, 24'hFF_FFFF);
        write_reg(psfwc_pkg::REG_THRESHOLD, 65535);
        write_reg(psfwc_pkg::REG_Z_PITCH, 65535);
        write_reg(psfwc_pkg::REG_Z_CENTER, 24'hFF_FFFF);
        write_reg(psfwc_pkg::REG_SIGMA, 65);
      end
      default: begin
        write_reg(psfwc_pkg::REG_AXIS_PITCH, 1);
        write_reg(psfwc_pkg::REG_AXIS_CENTER, 0);
        write_reg(psfwc_pkg::REG_THRESHOLD, 0);
        write_reg(psfwc_pkg::REG_Z_PITCH, 1);
        write_reg(psfwc_pkg::REG_Z_CENTER, 0);
        write_reg(psfwc_pkg::REG_SIGMA, 1);
      end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: no slices stored yet, so the window is empty
    query(24'd0);
    // zero weight slice
    pixel(16'd0, 10'd0, 1);
    pixel(16'hFFFF, 10'h3FF, 0);
    pixel(16'hFFFF, 10'd0, 1);
    // extreme pitch: products and sums saturate, width clamps
    drain();
    write_reg(psfwc_pkg::REG_AXIS_PITCH, 65535);
    pixel(16'hFFFF, 10'h3FF, 0);
    pixel(16'hFFFF, 10'h3FF, 0);
    pixel(16'hFFFF, 10'h3FF, 1);
    drain();
    write_reg(psfwc_pkg::REG_THRESHOLD, 65534);
    pixel(16'hFFFF, 10'h3FF, 0);
    pixel(16'h7FFF, 10'd5, 1);
    query(24'h80_0000);
    query(24'h7F_FFFF);
    // zero z pitch and zero sigma
    drain();
    write_reg(psfwc_pkg::REG_Z_PITCH, 0);
    write_reg(psfwc_pkg::REG_SIGMA, 0);
    write_reg(psfwc_pkg::REG_AXIS_CENTER, 24'hFF_FFFF);
    write_reg(psfwc_pkg::REG_Z_CENTER, 24'd2);
    query(24'd0);
    query(24'd1);
    pixel(16'hFFFF, 10'd3, 1);
    query(24'hFF_FFFF);
    // half-way z rounds away from zero; widest window
    drain();
    write_reg(psfwc_pkg::REG_Z_PITCH, 10);
    write_reg(psfwc_pkg::REG_Z_CENTER, 24'd0);
    write_reg(psfwc_pkg::REG_SIGMA, 127);
    query(24'hFF_FFF1);
    query(24'd15);
    query(24'hFF_FFC4);
    query(24'd25);

    // Random phases, idling pattern rotating through the four modes
    for (int ph = 0; ph < 12; ph++) begin
      int start;
      drain();
      rand_config(ph < 4 ? ph : (ph % 3 == 0 ? 1 : 0));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // long receiver hold-off with the sender still pushing
      if (ph == 4) hold_left = 3000;
      start = 0;
      while (start < 110) begin
        if (ph == 7 && start >= 40 && start < 44) drain();
        if ($urandom_range(4) == 0) begin
          rand_query();
          start++;
        end else begin
          rand_slice();
          start += 3;
        end
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
